// ===== src/mp3s2_pkg.sv =====
// ----------------------------------------------------------------------------
// mp3s2_pkg: shared types and constants of the 3x3 stride-2 max pool
// field widths, register indexes, reset values and the op classification
// ----------------------------------------------------------------------------
package mp3s2_pkg;

   // fixed field widths
   localparam int SAMPLE_W        = 16;
   localparam int HALF_WIDTH_W    = 7;
   localparam int HALF_HEIGHT_W   = 11;
   localparam int CHANNEL_COUNT_W = 7;
   localparam int ROW_W           = 11;

   // largest half height in use
   localparam logic [HALF_HEIGHT_W-1:0] HALF_HEIGHT_HIGH = 11'd1024;

   // register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [HALF_WIDTH_W-1:0]    HALF_WIDTH_RESET    = 7'd56;
   localparam logic [HALF_HEIGHT_W-1:0]   HALF_HEIGHT_RESET   = 11'd56;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 7'd64;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // where a word sits in the frame
   typedef struct packed {
      logic col_odd;
      logic col_zero;
      logic row_odd;
      logic row_zero;
      logic last;
   } op_flags_type;

endpackage

// ===== src/max_pool_3x3_stride2_core.sv =====
// path: the input word that finishes its window passes the two-entry queue, the stage
//   register and the output register, and back-pressure can hold it in any of them
// throughput: one input word per cycle while the output takes results; each store is read
//   on issue and written when the word leaves the stage, bypassed to the word that follows
// reset: positions clear, registers return to 56 / 56 / 64; the partial-max stores are
//   not cleared, every entry is written before its value is used within a frame
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_core: streaming 3x3 stride-2 max pool, padding left out
// NHWC input words in, one pooled word per channel per output pixel out
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2_core #(
   parameter int MAX_HALF_WIDTH = 64,
   parameter int MAX_CHANNELS   = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // input words
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [mp3s2_pkg::SAMPLE_W-1:0]    req_sample,
   // result words
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [mp3s2_pkg::SAMPLE_W-1:0]    rsp_max_value,
   output logic                                     rsp_last_of_frame,
   // register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mp3s2_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mp3s2_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int SW         = mp3s2_pkg::SAMPLE_W;
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int BAND_DEPTH = MAX_HALF_WIDTH * MAX_CHANNELS;
   localparam int BAND_AW    = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
   localparam int FLAGS_W    = $bits(mp3s2_pkg::op_flags_type);
   localparam int OP_W       = SW + CH_W + BAND_AW + FLAGS_W;
   localparam int Q_CNT_W    = $clog2(mp3s2_pkg::QUEUE_DEPTH + 1);

   // ---------------------------------------------------------------- registers
   logic [mp3s2_pkg::HALF_WIDTH_W-1:0]    half_width_ff, half_width_in;
   logic [mp3s2_pkg::HALF_HEIGHT_W-1:0]   half_height_ff, half_height_in;
   logic [mp3s2_pkg::CHANNEL_COUNT_W-1:0] channel_count_ff, channel_count_in;

   // writes are always taken; an index past the list is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      half_width_in    = half_width_ff;
      half_height_in   = half_height_ff;
      channel_count_in = channel_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mp3s2_pkg::CSR_HALF_WIDTH:
               half_width_in = csr_data[mp3s2_pkg::HALF_WIDTH_W-1:0];
            mp3s2_pkg::CSR_HALF_HEIGHT:
               half_height_in = csr_data[mp3s2_pkg::HALF_HEIGHT_W-1:0];
            mp3s2_pkg::CSR_CHANNEL_COUNT:
               channel_count_in = csr_data[mp3s2_pkg::CHANNEL_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff    <= mp3s2_pkg::HALF_WIDTH_RESET;
         half_height_ff   <= mp3s2_pkg::HALF_HEIGHT_RESET;
         channel_count_ff <= mp3s2_pkg::CHANNEL_COUNT_RESET;
      end else begin
         half_width_ff    <= half_width_in;
         half_height_ff   <= half_height_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // ---------------------------------------------------------------- front
   logic                    f_valid, f_ready;
   logic signed [SW-1:0]    f_sample;
   logic [CH_W-1:0]         f_chan;
   logic [BAND_AW-1:0]      f_band;
   mp3s2_pkg::op_flags_type f_flags;

   mp3s2_front #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .MAX_CHANNELS   (MAX_CHANNELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .half_width    (half_width_ff),
      .half_height   (half_height_ff),
      .channel_count (channel_count_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_sample     (req_sample),
      .op_valid      (f_valid),
      .op_ready      (f_ready),
      .op_sample     (f_sample),
      .op_chan       (f_chan),
      .op_band       (f_band),
      .op_flags      (f_flags)
   );

   // ---------------------------------------------------------------- queue
   // decouples position tracking from the store update so each side stalls alone
   logic [OP_W-1:0]    q_in_data, q_out_data;
   logic               q_out_valid, q_out_ready;
   logic [Q_CNT_W-1:0] q_count;
   logic               q_push, q_pop;

   assign q_in_data = {f_sample, f_chan, f_band, f_flags};
   assign q_push    = f_valid && f_ready;
   assign q_pop     = q_out_valid && q_out_ready;

   mp3s2_queue #(
      .WIDTH (OP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data),
      .count     (q_count)
   );

   // ---------------------------------------------------------------- back
   logic signed [SW-1:0]    b_sample;
   logic [CH_W-1:0]         b_chan;
   logic [BAND_AW-1:0]      b_band;
   mp3s2_pkg::op_flags_type b_flags;

   assign {b_sample, b_chan, b_band, b_flags} = q_out_data;

   mp3s2_back #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .MAX_CHANNELS   (MAX_CHANNELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_out_valid),
      .in_ready      (q_out_ready),
      .in_sample     (b_sample),
      .in_chan       (b_chan),
      .in_band       (b_band),
      .in_flags      (b_flags),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_max_value (rsp_max_value),
      .out_last      (rsp_last_of_frame)
   );

   // ---------------------------------------------------------------- checks
   // a full queue must hold off the input side
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (q_count == Q_CNT_W'(mp3s2_pkg::QUEUE_DEPTH)) |-> !req_ready)
      else $error("queue full but input still ready");

   // queue occupancy follows pushes and pops
   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (q_count == $past(q_count) + Q_CNT_W'($past(q_push)) - Q_CNT_W'($past(q_pop))))
      else $error("queue count out of step with push and pop");

   // a fresh result word comes from a word issued to the stores that left the stage register without a stall
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop, 2))
      else $error("result word without an issued word behind it");

endmodule

// ===== src/mp3s2_front.sv =====
// ----------------------------------------------------------------------------
// mp3s2_front: position tracking and word classification
// walks channel, column and row counters and tags each word for the back end
// ----------------------------------------------------------------------------
module mp3s2_front #(
   parameter int MAX_HALF_WIDTH = 64,
   parameter int MAX_CHANNELS   = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [mp3s2_pkg::HALF_WIDTH_W-1:0]       half_width,
   input  logic [mp3s2_pkg::HALF_HEIGHT_W-1:0]      half_height,
   input  logic [mp3s2_pkg::CHANNEL_COUNT_W-1:0]    channel_count,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [mp3s2_pkg::SAMPLE_W-1:0]    in_sample,
   output logic                                     op_valid,
   input  logic                                     op_ready,
   output logic signed [mp3s2_pkg::SAMPLE_W-1:0]    op_sample,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] op_chan,
   output logic [(((MAX_HALF_WIDTH * MAX_CHANNELS) > 1) ?
                  $clog2(MAX_HALF_WIDTH * MAX_CHANNELS) : 1)-1:0] op_band,
   output mp3s2_pkg::op_flags_type                  op_flags
);

   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int COL_W      = $clog2(2 * MAX_HALF_WIDTH);
   localparam int HALF_W     = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
   localparam int BAND_DEPTH = MAX_HALF_WIDTH * MAX_CHANNELS;
   localparam int BAND_AW    = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
   localparam int ROW_W      = mp3s2_pkg::ROW_W;

   logic [CH_W-1:0]  chan_pos_ff, chan_pos_in;
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;

   logic [CH_W-1:0]  last_ch;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] last_row;
   logic [7:0]       width_x2m1;
   logic [11:0]      height_x2m1;
   logic [HALF_W-1:0] col_half;
   logic             chan_wrap, col_wrap, row_wrap;
   logic             accept;

   // zero acts as one, too large acts as the bound
   assign width_x2m1  = {half_width, 1'b0} - 8'd1;
   assign height_x2m1 = {half_height, 1'b0} - 12'd1;

   always_comb begin
      if (channel_count == '0)
         last_ch = '0;
      else if (32'(channel_count) > MAX_CHANNELS)
         last_ch = CH_W'(MAX_CHANNELS - 1);
      else
         last_ch = CH_W'(channel_count - 7'd1);

      if (half_width == '0)
         last_col = COL_W'(1);
      else if (32'(half_width) > MAX_HALF_WIDTH)
         last_col = COL_W'(2 * MAX_HALF_WIDTH - 1);
      else
         last_col = COL_W'(width_x2m1);

      if (half_height == '0)
         last_row = ROW_W'(1);
      else if (half_height > mp3s2_pkg::HALF_HEIGHT_HIGH)
         last_row = '1;
      else
         last_row = ROW_W'(height_x2m1);
   end

   assign chan_wrap = chan_pos_ff >= last_ch;
   assign col_wrap  = col_pos_ff >= last_col;
   assign row_wrap  = row_pos_ff >= last_row;

   assign accept   = in_valid && op_ready;
   assign in_ready = op_ready;
   assign op_valid = in_valid;

   assign op_sample = in_sample;
   assign op_chan   = chan_pos_ff;
   assign col_half  = HALF_W'(col_pos_ff >> 1);
   assign op_band   = BAND_AW'(col_half) * BAND_AW'(MAX_CHANNELS) + BAND_AW'(chan_pos_ff);

   assign op_flags.col_odd  = col_pos_ff[0];
   assign op_flags.col_zero = (col_pos_ff == '0);
   assign op_flags.row_odd  = row_pos_ff[0];
   assign op_flags.row_zero = (row_pos_ff == '0);
   assign op_flags.last     = chan_wrap && col_wrap && row_wrap;

   always_comb begin
      chan_pos_in = chan_pos_ff;
      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      if (accept) begin
         if (chan_wrap) begin
            chan_pos_in = '0;
            if (col_wrap) begin
               col_pos_in = '0;
               row_pos_in = row_wrap ? '0 : row_pos_ff + ROW_W'(1);
            end else begin
               col_pos_in = col_pos_ff + COL_W'(1);
            end
         end else begin
            chan_pos_in = chan_pos_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
      end else begin
         chan_pos_ff <= chan_pos_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
      end
   end

endmodule

// ===== src/mp3s2_queue.sv =====
// ----------------------------------------------------------------------------
// mp3s2_queue: short queue between front and back
// two entries; a full queue refuses a push even as it pops, else push and pop in the same cycle
// ----------------------------------------------------------------------------
module mp3s2_queue #(
   parameter int WIDTH = 8
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [WIDTH-1:0]                                 in_data,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [WIDTH-1:0]                                 out_data,
   output logic [$clog2(mp3s2_pkg::QUEUE_DEPTH + 1)-1:0]    count
);

   localparam int DEPTH = mp3s2_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         slots_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/mp3s2_back.sv =====
// ----------------------------------------------------------------------------
// mp3s2_back: partial-max stores and result stage
// reads both stores on issue, updates them as the word leaves the stage register, with bypass
// ----------------------------------------------------------------------------
module mp3s2_back #(
   parameter int MAX_HALF_WIDTH = 64,
   parameter int MAX_CHANNELS   = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [mp3s2_pkg::SAMPLE_W-1:0]    in_sample,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] in_chan,
   input  logic [(((MAX_HALF_WIDTH * MAX_CHANNELS) > 1) ?
                  $clog2(MAX_HALF_WIDTH * MAX_CHANNELS) : 1)-1:0] in_band,
   input  mp3s2_pkg::op_flags_type                  in_flags,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [mp3s2_pkg::SAMPLE_W-1:0]    out_max_value,
   output logic                                     out_last
);

   localparam int SW         = mp3s2_pkg::SAMPLE_W;
   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int BAND_DEPTH = MAX_HALF_WIDTH * MAX_CHANNELS;
   localparam int BAND_AW    = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;

   function automatic logic signed [SW-1:0] max_of(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic signed [SW-1:0] row_partial_mem [MAX_CHANNELS];
   logic signed [SW-1:0] band_mem [BAND_DEPTH];

   logic                    stage_valid_ff, stage_valid_in;
   logic signed [SW-1:0]    stage_sample_ff;
   logic [CH_W-1:0]         stage_chan_ff;
   logic [BAND_AW-1:0]      stage_band_ff;
   mp3s2_pkg::op_flags_type stage_flags_ff;

   logic signed [SW-1:0] rp_rd_ff, bm_rd_ff;
   logic                 rp_fwd_hit_ff, bm_fwd_hit_ff;
   logic signed [SW-1:0] rp_fwd_data_ff, bm_fwd_data_ff;

   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_value_ff;
   logic                 out_last_ff;

   logic                 stage_result, stage_fire, issue;
   logic signed [SW-1:0] rp_cur, bm_cur, hmax, vmax;
   logic                 rp_we, bm_we;
   logic signed [SW-1:0] rp_wd, bm_wd;

   assign stage_result = stage_flags_ff.col_odd && stage_flags_ff.row_odd;
   assign stage_fire   = stage_valid_ff && (!stage_result || !out_valid_ff || out_ready);
   assign in_ready     = !stage_valid_ff || stage_fire;
   assign issue        = in_valid && in_ready;

   // bypass the write that lands on the same edge as the read
   assign rp_cur = rp_fwd_hit_ff ? rp_fwd_data_ff : rp_rd_ff;
   assign bm_cur = bm_fwd_hit_ff ? bm_fwd_data_ff : bm_rd_ff;
   assign hmax   = max_of(rp_cur, stage_sample_ff);
   assign vmax   = max_of(bm_cur, hmax);

   assign rp_we = stage_fire;
   assign rp_wd = (stage_flags_ff.col_odd || stage_flags_ff.col_zero) ? stage_sample_ff : hmax;
   assign bm_we = stage_fire && stage_flags_ff.col_odd;
   assign bm_wd = (stage_flags_ff.row_odd || stage_flags_ff.row_zero) ? hmax : vmax;

   always_ff @(posedge clock) begin
      if (rp_we)
         row_partial_mem[stage_chan_ff] <= rp_wd;
      if (issue) begin
         rp_rd_ff       <= row_partial_mem[in_chan];
         rp_fwd_hit_ff  <= rp_we && (stage_chan_ff == in_chan);
         rp_fwd_data_ff <= rp_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_we)
         band_mem[stage_band_ff] <= bm_wd;
      if (issue) begin
         bm_rd_ff       <= band_mem[in_band];
         bm_fwd_hit_ff  <= bm_we && (stage_band_ff == in_band);
         bm_fwd_data_ff <= bm_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         stage_sample_ff <= in_sample;
         stage_chan_ff   <= in_chan;
         stage_band_ff   <= in_band;
         stage_flags_ff  <= in_flags;
      end
      if (stage_fire && stage_result) begin
         out_value_ff <= vmax;
         out_last_ff  <= stage_flags_ff.last;
      end
   end

   always_comb begin
      stage_valid_in = issue || (stage_valid_ff && !stage_fire);
      out_valid_in   = (stage_fire && stage_result) || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_max_value = out_value_ff;
   assign out_last      = out_last_ff;

endmodule
